@@ rtl/dth_pkg.sv @@
// Shared types and constants for the differential turn hysteresis block.
// Used by the register file, controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps

package dth_pkg;

    localparam int ANGLE_W    = 15;
    localparam int MAG_W      = 15;
    localparam int SPEED_W    = 16;
    localparam int THR_W      = 14;
    localparam int OUT_W      = 18;
    localparam int PROD_W     = MAG_W + SPEED_W;
    localparam int QUO_W      = SPEED_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [THR_W-1:0]   HARD_THR_RST     = 14'd6434;
    localparam logic [THR_W-1:0]   SOFT_THR_RST     = 14'd5004;
    localparam logic [THR_W-1:0]   STRAIGHT_THR_RST = 14'd715;
    localparam logic [SPEED_W-1:0] SPEED_CAP_RST    = 16'd2560;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_SOFT     = 2'd1,
        MODE_HARD     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_HARD_THR     = 2'd0,
        REG_SOFT_THR     = 2'd1,
        REG_STRAIGHT_THR = 2'd2,
        REG_SPEED_CAP    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]   hard_thr;
        logic [THR_W-1:0]   soft_thr;
        logic [THR_W-1:0]   straight_thr;
        logic [SPEED_W-1:0] speed_cap;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ rtl/differential_turn_hysteresis.sv @@
// Channel    | Handshake           | Payload
// input      | in_valid / in_ready | heading_angle, heading_length
// output     | out_valid/out_ready | left_speed, right_speed, turn_mode
// config     | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// An item passes from its input transfer through a capture, a multiply, 16
// steps of the restoring divider and one load into the output register, where
// the result then shows as valid.
// Reset clears the turning mode to straight and the registers to their defaults.
// A held output stalls the block in its final step, and no input is taken
// until the result has moved into the output register.
// Top level of the differential turn hysteresis block; uses dth_pkg, dth_regs,
// dth_ctrl and dth_dp.
`timescale 1ns / 1ps

module differential_turn_hysteresis (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [dth_pkg::APB_ADDR_W-1:0] paddr,
    input  logic        [dth_pkg::APB_DATA_W-1:0] pwdata,
    output logic        [dth_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [dth_pkg::ANGLE_W-1:0]   heading_angle,
    input  logic        [dth_pkg::SPEED_W-1:0]   heading_length,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dth_pkg::OUT_W-1:0]     left_speed,
    output logic signed [dth_pkg::OUT_W-1:0]     right_speed,
    output logic        [1:0]                    turn_mode
);

    dth_pkg::cfg_t    cfg;
    dth_pkg::cmd_t    cmd;
    dth_pkg::status_t status;

    assign pready = 1'b1;

    dth_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dth_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .heading_angle  (heading_angle),
        .heading_length (heading_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .turn_mode      (turn_mode)
    );

endmodule

@@ rtl/dth_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on dth_pkg for the register map, reset values and the cfg_t struct.
`timescale 1ns / 1ps

module dth_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dth_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dth_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dth_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,
    output dth_pkg::cfg_t                  cfg
);

    dth_pkg::cfg_t     cfg_reg;
    dth_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = dth_pkg::reg_idx_t'(paddr[dth_pkg::APB_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite && pready;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hard_thr     <= dth_pkg::HARD_THR_RST;
            cfg_reg.soft_thr     <= dth_pkg::SOFT_THR_RST;
            cfg_reg.straight_thr <= dth_pkg::STRAIGHT_THR_RST;
            cfg_reg.speed_cap    <= dth_pkg::SPEED_CAP_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                dth_pkg::REG_HARD_THR:
                    cfg_reg.hard_thr <= pwdata[dth_pkg::THR_W-1:0];
                dth_pkg::REG_SOFT_THR:
                    cfg_reg.soft_thr <= pwdata[dth_pkg::THR_W-1:0];
                dth_pkg::REG_STRAIGHT_THR:
                    cfg_reg.straight_thr <= pwdata[dth_pkg::THR_W-1:0];
                dth_pkg::REG_SPEED_CAP:
                    cfg_reg.speed_cap <= pwdata[dth_pkg::SPEED_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            dth_pkg::REG_HARD_THR:
                prdata = dth_pkg::APB_DATA_W'(cfg_reg.hard_thr);
            dth_pkg::REG_SOFT_THR:
                prdata = dth_pkg::APB_DATA_W'(cfg_reg.soft_thr);
            dth_pkg::REG_STRAIGHT_THR:
                prdata = dth_pkg::APB_DATA_W'(cfg_reg.straight_thr);
            dth_pkg::REG_SPEED_CAP:
                prdata = dth_pkg::APB_DATA_W'(cfg_reg.speed_cap);
        endcase
    end

endmodule

@@ rtl/dth_ctrl.sv @@
// Sequencing state machine: capture, mode update, divide steps, result load.
// Depends on dth_pkg for the command and status structs and the step count.
`timescale 1ns / 1ps

module dth_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dth_pkg::status_t  status,
    output dth_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [dth_pkg::CNT_W-1:0] cnt_reg;
    logic                      last_step;

    assign last_step = (cnt_reg == dth_pkg::CNT_W'(dth_pkg::DIV_STEPS - 1));
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_DONE) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = ST_DIV;
            ST_DIV:
                if (last_step)
                    state_next = ST_DONE;
            ST_DONE:
                if (status.out_free)
                    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + dth_pkg::CNT_W'(1);
        end
    end

    // A result is only written into the output register when it has room.
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while output register is occupied");

    a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !in_ready)
        else $error("input ready right after a transfer");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && last_step) |=> state_reg == ST_DONE)
        else $error("divide sequence did not end after the last step");

endmodule

@@ rtl/dth_dp.sv @@
// Datapath: angle magnitude, base speed, turning mode, restoring divider and
// the output register. Depends on dth_pkg for widths, mode codes and structs.
`timescale 1ns / 1ps

module dth_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dth_pkg::cfg_t                        cfg,
    input  dth_pkg::cmd_t                        cmd,
    output dth_pkg::status_t                     status,
    input  logic signed [dth_pkg::ANGLE_W-1:0]   heading_angle,
    input  logic        [dth_pkg::SPEED_W-1:0]   heading_length,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dth_pkg::OUT_W-1:0]     left_speed,
    output logic signed [dth_pkg::OUT_W-1:0]     right_speed,
    output logic        [1:0]                    turn_mode
);

    logic [dth_pkg::MAG_W-1:0]   mag_reg;
    logic [dth_pkg::SPEED_W-1:0] base_reg;
    logic                        pos_reg;
    dth_pkg::mode_t              mode_reg;
    dth_pkg::mode_t              mode_next;
    logic [dth_pkg::THR_W-1:0]   rem_reg;
    logic [dth_pkg::QUO_W-1:0]   quo_reg;
    logic                        out_valid_reg;
    logic [dth_pkg::OUT_W-1:0]   left_reg;
    logic [dth_pkg::OUT_W-1:0]   right_reg;
    logic [1:0]                  mode_out_reg;

    logic [dth_pkg::MAG_W-1:0]   in_mag;
    logic [dth_pkg::SPEED_W-1:0] in_base;
    logic                        in_pos;
    logic [dth_pkg::MAG_W-1:0]   hard_x;
    logic [dth_pkg::MAG_W-1:0]   soft_x;
    logic [dth_pkg::MAG_W-1:0]   straight_x;
    logic [dth_pkg::PROD_W-1:0]  product;
    logic [dth_pkg::THR_W:0]     trial;
    logic [dth_pkg::THR_W:0]     divisor;
    logic [dth_pkg::THR_W:0]     trial_diff;
    logic                        trial_ge;
    logic [dth_pkg::QUO_W-1:0]   d_val;
    logic [dth_pkg::SPEED_W:0]   sum_val;
    logic [dth_pkg::SPEED_W:0]   diff_val;
    logic [dth_pkg::OUT_W-1:0]   s1;
    logic [dth_pkg::OUT_W-1:0]   s2;

    // The most negative angle keeps its full magnitude in the 15-bit result.
    assign in_mag  = heading_angle[dth_pkg::ANGLE_W-1]
                   ? (dth_pkg::MAG_W'(0) - dth_pkg::MAG_W'(heading_angle))
                   : dth_pkg::MAG_W'(heading_angle);
    assign in_base = (heading_length < cfg.speed_cap) ? heading_length : cfg.speed_cap;
    assign in_pos  = !heading_angle[dth_pkg::ANGLE_W-1] && (heading_angle != '0);

    assign hard_x     = dth_pkg::MAG_W'(cfg.hard_thr);
    assign soft_x     = dth_pkg::MAG_W'(cfg.soft_thr);
    assign straight_x = dth_pkg::MAG_W'(cfg.straight_thr);

    // Cascaded hysteresis: hard may relax first, then soft, then straight is judged.
    always_comb
    begin
        mode_next = mode_reg;
        if (mode_next == dth_pkg::MODE_HARD && mag_reg <= soft_x)
            mode_next = dth_pkg::MODE_SOFT;
        if (mode_next == dth_pkg::MODE_SOFT)
        begin
            if (mag_reg > hard_x)
                mode_next = dth_pkg::MODE_HARD;
            else if (mag_reg <= straight_x)
                mode_next = dth_pkg::MODE_STRAIGHT;
        end
        if (mode_next == dth_pkg::MODE_STRAIGHT)
        begin
            if (mag_reg > hard_x)
                mode_next = dth_pkg::MODE_HARD;
            else if (mag_reg > straight_x)
                mode_next = dth_pkg::MODE_SOFT;
        end
    end

    assign product = dth_pkg::PROD_W'(base_reg) * dth_pkg::PROD_W'(mag_reg);

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    assign divisor    = {1'b0, cfg.hard_thr};
    assign trial      = {rem_reg, quo_reg[dth_pkg::QUO_W-1]};
    assign trial_ge   = (trial >= divisor);
    assign trial_diff = trial - divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= dth_pkg::MODE_STRAIGHT;
        else if (cmd.update)
            mode_reg <= mode_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg  <= in_mag;
            base_reg <= in_base;
            pos_reg  <= in_pos;
        end
        // Outside hard mode the quotient never exceeds the base speed, so the upper
        // product bits already sit below the divisor and seed the remainder.
        if (cmd.update)
        begin
            rem_reg <= product[dth_pkg::QUO_W +: dth_pkg::THR_W];
            quo_reg <= product[dth_pkg::QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[dth_pkg::THR_W-1:0]
                                : trial[dth_pkg::THR_W-1:0];
            quo_reg <= {quo_reg[dth_pkg::QUO_W-2:0], trial_ge};
        end
    end

    // A zero hard threshold only admits soft mode at zero angle, where d is zero.
    assign d_val    = (cfg.hard_thr == '0) ? '0 : quo_reg;
    assign sum_val  = {1'b0, base_reg} + {1'b0, d_val};
    assign diff_val = {1'b0, base_reg} - {1'b0, d_val};

    always_comb
    begin
        case (mode_reg)
            dth_pkg::MODE_SOFT:
            begin
                s1 = dth_pkg::OUT_W'(diff_val);
                s2 = dth_pkg::OUT_W'(sum_val);
            end
            dth_pkg::MODE_HARD:
            begin
                s1 = dth_pkg::OUT_W'(0) - dth_pkg::OUT_W'(cfg.speed_cap);
                s2 = dth_pkg::OUT_W'(cfg.speed_cap);
            end
            default:
            begin
                s1 = dth_pkg::OUT_W'(base_reg);
                s2 = dth_pkg::OUT_W'(base_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            left_reg     <= pos_reg ? s1 : s2;
            right_reg    <= pos_reg ? s2 : s1;
            mode_out_reg <= mode_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign left_speed      = left_reg;
    assign right_speed     = right_reg;
    assign turn_mode       = mode_out_reg;

    // In soft mode the angle is at most the hard threshold, so d cannot pass base.
    a_soft_d_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && mode_reg == dth_pkg::MODE_SOFT && cfg.hard_thr != '0)
        |-> quo_reg <= base_reg)
        else $error("soft-turn offset exceeds base speed");

    a_straight_below_hard: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && mode_reg == dth_pkg::MODE_STRAIGHT) |-> mag_reg <= hard_x)
        else $error("straight mode kept with angle above hard threshold");

endmodule

@@ test/dth_checker.sv @@
// Checker for the differential turn hysteresis block: follows register writes, predicts
// the wheel speeds and turning mode for every input transfer and compares result transfers.
// Depends on dth_pkg for the register, mode and configuration types.
`timescale 1ns / 1ps

module dth_checker
    import dth_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [ANGLE_W-1:0] heading_angle,
    input  logic [SPEED_W-1:0]        heading_length,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [OUT_W-1:0]   left_speed,
    input  logic signed [OUT_W-1:0]   right_speed,
    input  logic [1:0]                turn_mode,
    output int unsigned               failures,
    output int unsigned               pending
);

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        mode_t                   mode;
    } wheel_cmd_t;

    cfg_t       cfg;
    mode_t      mode_now;
    wheel_cmd_t wheel_cmds[$];

    // Advances the turning mode and returns the wheel command for one heading.
    function automatic wheel_cmd_t steer(input logic [ANGLE_W-1:0] angle,
                                         input logic [SPEED_W-1:0] length);
        logic [ANGLE_W:0]        mag;
        logic [SPEED_W-1:0]      base;
        logic [31:0]             prod;
        logic [31:0]             quo;
        logic signed [OUT_W-1:0] inner;
        logic signed [OUT_W-1:0] outer;
        logic                    positive;
        wheel_cmd_t              cmd;
        // The most negative pattern has a magnitude one beyond the positive range.
        mag = angle[ANGLE_W-1] ? ((16'd1 << ANGLE_W) - {1'b0, angle}) : {1'b0, angle};
        positive = !angle[ANGLE_W-1] && (angle != '0);
        base = (length < cfg.speed_cap) ? length : cfg.speed_cap;

        // The mode moves in cascade, so one heading can pass through several modes.
        if (mode_now == MODE_HARD && mag <= cfg.soft_thr)
        begin
            mode_now = MODE_SOFT;
        end
        if (mode_now == MODE_SOFT)
        begin
            if (mag > cfg.hard_thr)
            begin
                mode_now = MODE_HARD;
            end
            else if (mag <= cfg.straight_thr)
            begin
                mode_now = MODE_STRAIGHT;
            end
        end
        if (mode_now == MODE_STRAIGHT)
        begin
            if (mag > cfg.hard_thr)
            begin
                mode_now = MODE_HARD;
            end
            else if (mag > cfg.straight_thr)
            begin
                mode_now = MODE_SOFT;
            end
        end

        case (mode_now)
            MODE_SOFT:
            begin
                prod = 32'(base) * 32'(mag);
                quo = (cfg.hard_thr != '0) ? prod / 32'(cfg.hard_thr) : '0;
                if (quo > 32'(base))
                begin
                    quo = 32'(base);
                end
                inner = OUT_W'(base) - OUT_W'(quo);
                outer = OUT_W'(base) + OUT_W'(quo);
            end
            MODE_HARD:
            begin
                inner = OUT_W'(0) - OUT_W'(cfg.speed_cap);
                outer = OUT_W'(cfg.speed_cap);
            end
            default:
            begin
                inner = OUT_W'(base);
                outer = OUT_W'(base);
            end
        endcase

        cmd.left  = positive ? inner : outer;
        cmd.right = positive ? outer : inner;
        cmd.mode  = mode_now;
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wheel_cmd_t  want;
        int unsigned bad;
        if (!rst_n)
        begin
            cfg = {HARD_THR_RST, SOFT_THR_RST, STRAIGHT_THR_RST, SPEED_CAP_RST};
            mode_now = MODE_STRAIGHT;
            wheel_cmds.delete();
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_HARD_THR:     cfg.hard_thr     = pwdata[THR_W-1:0];
                    REG_SOFT_THR:     cfg.soft_thr     = pwdata[THR_W-1:0];
                    REG_STRAIGHT_THR: cfg.straight_thr = pwdata[THR_W-1:0];
                    REG_SPEED_CAP:    cfg.speed_cap    = pwdata[SPEED_W-1:0];
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (wheel_cmds.size() == 0)
                begin
                    $display("%0t: result with nothing expected: left %0d right %0d mode %0d",
                             $time, left_speed, right_speed, turn_mode);
                    bad++;
                end
                else
                begin
                    want = wheel_cmds.pop_front();
                    if (left_speed !== want.left)
                    begin
                        $display("%0t: left_speed mismatch: expected %0d, got %0d",
                                 $time, want.left, left_speed);
                        bad++;
                    end
                    if (right_speed !== want.right)
                    begin
                        $display("%0t: right_speed mismatch: expected %0d, got %0d",
                                 $time, want.right, right_speed);
                        bad++;
                    end
                    if (turn_mode !== want.mode)
                    begin
                        $display("%0t: turn_mode mismatch: expected %0d, got %0d",
                                 $time, want.mode, turn_mode);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                wheel_cmds.push_back(steer(heading_angle, heading_length));
            end
            failures <= failures + bad;
            pending <= wheel_cmds.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the differential turn hysteresis block: clock, reset, register
// setup, heading stimulus and result back-pressure, with the verdict at the end.
// Depends on dth_pkg, the block itself and dth_checker.
`timescale 1ns / 1ps

module tb_top;
    import dth_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned SETTLE       = 40;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned DIRECTED_NUM = 21;

    localparam int DIR_ANGLE [DIRECTED_NUM] = '{
        0, 0, 12868, -12868, -16384, 16383, 715, 716, -716, 6434, 6435,
        5005, 5004, 715, -6435, -715, 1, -1, 4000, -4000, 0
    };
    localparam int DIR_LENGTH [DIRECTED_NUM] = '{
        0, 65535, 65535, 1000, 2560, 100, 2000, 2000, 3000, 2560, 2560,
        2559, 2561, 65535, 0, 500, 1, 65535, 2560, 65535, 1234
    };

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [ANGLE_W-1:0] heading_angle;
    logic [SPEED_W-1:0]      heading_length;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] left_speed;
    logic signed [OUT_W-1:0] right_speed;
    logic [1:0]              turn_mode;

    int unsigned failures;
    int unsigned pending;
    int unsigned cycle_count;
    logic        steady;
    logic        hold_req;

    // Thresholds in force, used to aim headings at the mode boundaries.
    int unsigned thr_hard;
    int unsigned thr_soft;
    int unsigned thr_straight;
    int unsigned speed_max;

    differential_turn_hysteresis i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .heading_angle  (heading_angle),
        .heading_length (heading_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .turn_mode      (turn_mode)
    );

    dth_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .heading_angle  (heading_angle),
        .heading_length (heading_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .turn_mode      (turn_mode),
        .failures       (failures),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) != 0)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        int          mag;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)
        begin
            mag = int'(thr_straight) + int'($urandom_range(0, 8)) - 4;
        end
        else if (pick < 8)
        begin
            mag = int'(thr_soft) + int'($urandom_range(0, 8)) - 4;
        end
        else if (pick < 12)
        begin
            mag = int'(thr_hard) + int'($urandom_range(0, 8)) - 4;
        end
        else if (pick < 16)
        begin
            mag = $urandom_range(0, 12868);
        end
        else if (pick == 16)
        begin
            mag = 0;
        end
        else if (pick == 17)
        begin
            mag = 12868;
        end
        else if (pick == 18)
        begin
            return ANGLE_W'($urandom);
        end
        else
        begin
            // Beyond the stated range of pi, up to the most negative pattern.
            mag = $urandom_range(12869, 16384);
        end
        if (mag < 0)
        begin
            mag = 0;
        end
        if (mag > 16384)
        begin
            mag = 16384;
        end
        return $urandom_range(0, 1) ? ANGLE_W'(-mag) : ANGLE_W'(mag);
    endfunction

    function automatic logic [SPEED_W-1:0] pick_length();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 9);
        span = (speed_max * 2 > 65535) ? 65535 : speed_max * 2;
        if (pick < 6)
        begin
            return SPEED_W'($urandom_range(0, span));
        end
        else if (pick == 6)
        begin
            return '0;
        end
        else if (pick == 7)
        begin
            return '1;
        end
        return SPEED_W'($urandom);
    endfunction

    task automatic send_heading(input logic [ANGLE_W-1:0] angle,
                                input logic [SPEED_W-1:0] length);
        in_valid <= 1'b1;
        heading_angle <= angle;
        heading_length <= length;
        do @(posedge clk); while (!in_ready);
    endtask

    // The last item leaves valid high; the caller always drops it next.
    task automatic run_items(input int unsigned count);
        int unsigned gap;
        for (int unsigned k = 0; k < count; k++)
        begin
            send_heading(pick_angle(), pick_length());
            gap = (k + 1 == count || steady || $urandom_range(0, 1) != 0) ? 0 : idle_len();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops offering and waits until every expected result has been transferred.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        // Bits above the register width carry junk and must be dropped.
        if (idx == REG_SPEED_CAP)
        begin
            pwdata <= {16'($urandom), 16'(value)};
        end
        else
        begin
            pwdata <= {18'($urandom), 14'(value)};
        end
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned hard, input int unsigned soft_lim,
                              input int unsigned straight, input int unsigned top_speed);
        wait_idle();
        write_reg(REG_HARD_THR, hard);
        write_reg(REG_SOFT_THR, soft_lim);
        write_reg(REG_STRAIGHT_THR, straight);
        write_reg(REG_SPEED_CAP, top_speed);
        thr_hard = hard;
        thr_soft = soft_lim;
        thr_straight = straight;
        speed_max = top_speed;
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial
    begin : result_sink
        int unsigned idle_left;
        logic        hold_taken;
        idle_left = 0;
        hold_taken = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                idle_left = LONG_HOLD;
            end
            else if (idle_left == 0 && !steady && $urandom_range(0, 4) == 0)
            begin
                idle_left = idle_len();
            end
            if (idle_left != 0)
            begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned straight;
        int unsigned soft_lim;
        int unsigned hard;
        int unsigned top_speed;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        heading_angle = '0;
        heading_length = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        thr_hard = HARD_THR_RST;
        thr_soft = SOFT_THR_RST;
        thr_straight = STRAIGHT_THR_RST;
        speed_max = SPEED_CAP_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: mode boundaries, swaps and cascaded mode changes.
        for (int k = 0; k < DIRECTED_NUM; k++)
        begin
            send_heading(ANGLE_W'(DIR_ANGLE[k]), SPEED_W'(DIR_LENGTH[k]));
        end

        set_config(1, 0, 0, 65535);
        run_items(110);
        set_config(12868, 12868, 12868, 0);
        run_items(70);
        // A zero hard threshold leaves no reachable soft turn with a nonzero angle.
        set_config(0, 0, 0, 1);
        run_items(50);
        set_config(16383, 16383, 16383, 65535);
        run_items(50);

        for (int ph = 0; ph < 6; ph++)
        begin
            straight = $urandom_range(0, 3000);
            soft_lim = straight + $urandom_range(0, 4000);
            hard = soft_lim + $urandom_range(1, 4000);
            if (hard > 12868)
            begin
                hard = 12868;
            end
            top_speed = $urandom_range(0, 1) ? $urandom_range(1, 4000) : $urandom_range(0, 65535);
            if (ph == 5)
            begin
                straight = $urandom_range(0, 12868);
                soft_lim = $urandom_range(0, 12868);
                hard = $urandom_range(1, 12868);
            end
            set_config(hard, soft_lim, straight, top_speed);
            steady <= (ph == 1);
            if (ph == 2)
            begin
                hold_req <= 1'b1;
            end
            if (ph == 3)
            begin
                run_items(50);
                wait_idle();
                run_items(60);
            end
            else
            begin
                run_items(110);
            end
        end

        wait_idle();
        if (failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
